// File: sv/bce_pkg.sv
// Package for the banked 24-bit execute core: opcodes, conditions, widths and sequencer states.
// No dependencies; the divider, the ALU and the execute core import it.
`default_nettype none
package bce_pkg;
   localparam int WORD_BITS = 24;
   localparam int MEM_ADDR_BITS_DEF = 16;
   localparam int BANK_COUNT_DEF = 5;
   localparam int PIN_COUNT = 16;
   localparam logic [WORD_BITS-1:0] WORD_MASK = 24'd16777215;

   typedef enum logic [3:0] {
      OP_SET = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
      OP_MOD = 4'd5, OP_WRITE = 4'd6, OP_READ = 4'd7, OP_IF = 4'd8, OP_JMP = 4'd9,
      OP_BANK = 4'd10, OP_HALT = 4'd11, OP_OUT = 4'd12, OP_IN = 4'd13,
      OP_RSV14 = 4'd14, OP_RSV15 = 4'd15
   } opcode_type;

   localparam logic [3:0] CND_AEQB = 4'd0, CND_AEQC = 4'd1, CND_BEQC = 4'd2,
      CND_AGTB = 4'd3, CND_AGTC = 4'd4, CND_CGTB = 4'd5, CND_AND = 4'd6,
      CND_OR = 4'd7, CND_NOT = 4'd8, CND_XOR = 4'd9;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_DIVIDE, ST_MEMWAIT, ST_COMMIT, ST_RESPOND
   } state_type;

   typedef enum logic [1:0] {
      ALU_ADD, ALU_SUB, ALU_MUL
   } alu_op_type;

   // Control from the sequencer to the divider.
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage
`default_nettype wire

// File: sv/bce_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module bce_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// File: sv/bce_divider.sv
// Restoring divider, one quotient bit per cycle, for divide and modulo.
// Depends on bce_pkg.
`default_nettype none
module bce_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bce_pkg::div_ctrl_type        ctrl,
   input  wire logic [bce_pkg::WORD_BITS-1:0] dividend,
   input  wire logic [bce_pkg::WORD_BITS-1:0] divisor,
   output bce_pkg::div_stat_type             stat,
   output logic      [bce_pkg::WORD_BITS-1:0] quotient,
   output logic      [bce_pkg::WORD_BITS-1:0] remainder
);
   import bce_pkg::*;
   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [WORD_BITS:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WORD_BITS-1]} - {1'b0, dvs_ff};
      if (ctrl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_BITS'(WORD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift the next dividend bit into the partial remainder and try a subtract.
         if (!trial[WORD_BITS]) begin
            rem_in = trial[WORD_BITS-1:0];
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WORD_BITS-2:0], quo_ff[WORD_BITS-1]};
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// File: sv/bce_alu.sv
// Shared arithmetic unit: 24-bit add, subtract with borrow, and multiply with overflow.
// Depends on bce_pkg.
`default_nettype none
module bce_alu (
   input  wire bce_pkg::alu_op_type           op,
   input  wire logic [bce_pkg::WORD_BITS-1:0] a,
   input  wire logic [bce_pkg::WORD_BITS-1:0] b,
   output logic      [bce_pkg::WORD_BITS-1:0] result,
   output logic                               carry
);
   import bce_pkg::*;
   logic [2*WORD_BITS-1:0] prod;
   logic [WORD_BITS:0]     sum;

   always_comb begin
      prod = '0;
      sum  = '0;
      unique case (op)
         ALU_ADD: begin
            sum    = {1'b0, a} + {1'b0, b};
            result = sum[WORD_BITS-1:0];
            carry  = sum[WORD_BITS];
         end
         ALU_SUB: begin
            sum    = {1'b0, a} - {1'b0, b};
            result = sum[WORD_BITS-1:0];
            carry  = sum[WORD_BITS];
         end
         ALU_MUL: begin
            prod   = a * b;
            result = prod[WORD_BITS-1:0];
            carry  = |prod[2*WORD_BITS-1:WORD_BITS];
         end
         default: begin
            result = '0;
            carry  = 1'b0;
         end
      endcase
   end
endmodule
`default_nettype wire

// File: sv/banked_24bit_cpu_execute_core.sv
// Execute core of a banked 24-bit processor: one instruction word in, one status word out.
// Most words pass through the states accept, operand read, commit and respond, with the
// status word valid in the respond state; reads add a memory wait state, and divide and modulo
// by a non-zero divisor add a divide state (one quotient bit a cycle in the shared divider).
// One word at a time: the next is taken once the response has been accepted.
// Synchronous reset clears registers, flags, bank, pins and program counter;
// data memory is undefined until written.
`default_nettype none
module banked_24bit_cpu_execute_core #(
   parameter int MEM_ADDR_BITS = bce_pkg::MEM_ADDR_BITS_DEF,
   parameter int BANK_COUNT    = bce_pkg::BANK_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_opcode,
   input  wire logic        req_first_is_reg,
   input  wire logic [1:0]  req_first_reg,
   input  wire logic        req_second_is_reg,
   input  wire logic [1:0]  req_second_reg,
   input  wire logic [23:0] req_immediate,
   input  wire logic [3:0]  req_condition,
   input  wire logic [15:0] req_pins_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [23:0]      rsp_next_pc,
   output logic             rsp_halted,
   output logic [15:0]      rsp_pins_out,
   output logic             rsp_carry_out,
   output logic             rsp_zero_recent,
   output logic             rsp_divide_fault
);
   import bce_pkg::*;
   localparam int SLOTS = 3 * BANK_COUNT;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BANK_BITS = 3;

   state_type state_ff, state_in;

   // Latched instruction word.
   opcode_type           op_ff;
   logic                 fr_ff, sr_ff;
   logic [1:0]           fs_ff, ss_ff;
   logic [WORD_BITS-1:0] imm_ff;
   logic [3:0]           cond_ff;
   logic [PIN_COUNT-1:0] pins_ff;

   // Operands, registered from the register file or the immediate.
   logic [WORD_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [WORD_BITS-1:0] ra_ff, rb_ff, rc_ff, ra_in, rb_in, rc_in;

   logic [WORD_BITS-1:0] regs_ff [SLOTS];
   logic [WORD_BITS-1:0] pc_ff;
   logic [BANK_BITS-1:0] bank_ff;
   logic                 carry_ff, halt_ff, fault_ff;
   logic [1:0]           zh_ff;
   logic [PIN_COUNT-1:0] pinlv_ff;

   // Commit-time next values.
   logic [WORD_BITS-1:0] pc_in, wr_val;
   logic [BANK_BITS-1:0] bank_in;
   logic                 carry_in, halt_in, fault_in, wr_en;
   logic [1:0]           zh_in;
   logic [PIN_COUNT-1:0] pinlv_in;
   logic                 commit;

   logic [SLOT_BITS-1:0] slot_f;

   function automatic logic [SLOT_BITS-1:0] slot_of(input logic [BANK_BITS-1:0] bk,
                                                   input logic [1:0] sel);
      logic [1:0] s;
      logic [5:0] i;
      s = (sel > 2'd2) ? 2'd2 : sel;
      i = 6'(bk) * 6'd3 + 6'(s);
      return (i < 6'(SLOTS)) ? SLOT_BITS'(i) : SLOT_BITS'(SLOTS - 1);
   endfunction

   // Shared units.
   alu_op_type           alu_op;
   logic [WORD_BITS-1:0] alu_res;
   logic                 alu_carry;
   div_ctrl_type         dctrl;
   div_stat_type         dstat;
   logic [WORD_BITS-1:0] quo, rem;
   logic [WORD_BITS-1:0] mem_rd;
   logic                 mem_we;
   logic [MEM_ADDR_BITS-1:0] mem_addr;

   bce_alu u_alu (.op(alu_op), .a(a_ff), .b(b_ff), .result(alu_res), .carry(alu_carry));

   // The divider and the memory are started in the operand read cycle, so they take the
   // operands as they are being fetched.
   bce_divider u_div (
      .clock(clock), .reset(reset), .ctrl(dctrl), .dividend(a_in), .divisor(b_in),
      .stat(dstat), .quotient(quo), .remainder(rem)
   );

   bce_ram #(.WIDTH(WORD_BITS), .DEPTH(2 ** MEM_ADDR_BITS)) u_mem (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr), .wr_data(b_in), .rd_data(mem_rd)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_READ;
         ST_READ: begin
            if (halt_ff) state_in = ST_COMMIT;
            else if ((op_ff == OP_DIV || op_ff == OP_MOD) && fr_ff && (b_in != '0))
               state_in = ST_DIVIDE;
            else if (op_ff == OP_READ) state_in = ST_MEMWAIT;
            else state_in = ST_COMMIT;
         end
         ST_DIVIDE:  if (dstat.done) state_in = ST_COMMIT;
         ST_MEMWAIT: state_in = ST_COMMIT;
         ST_COMMIT:  state_in = ST_RESPOND;
         ST_RESPOND: if (rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      rsp_valid   = (state_ff == ST_RESPOND);
      commit      = (state_ff == ST_COMMIT) && !halt_ff;
      dctrl.start = (state_ff == ST_READ) && !halt_ff && fr_ff &&
                    (op_ff == OP_DIV || op_ff == OP_MOD) && (b_in != '0);
      mem_we      = (state_ff == ST_READ) && !halt_ff && (op_ff == OP_WRITE);
      mem_addr    = (op_ff == OP_WRITE) ? a_in[MEM_ADDR_BITS-1:0] : b_in[MEM_ADDR_BITS-1:0];
      unique case (op_ff)
         OP_SUB:  alu_op = ALU_SUB;
         OP_MUL:  alu_op = ALU_MUL;
         default: alu_op = ALU_ADD;
      endcase
   end

   // Operand fetch: in ST_READ the register file is read through the current bank.
   assign slot_f = slot_of(bank_ff, fs_ff);
   always_comb begin
      ra_in = regs_ff[slot_of(bank_ff, 2'd0)];
      rb_in = regs_ff[slot_of(bank_ff, 2'd1)];
      rc_in = regs_ff[slot_of(bank_ff, 2'd2)];
      a_in  = fr_ff ? regs_ff[slot_f] : imm_ff;
      b_in  = sr_ff ? regs_ff[slot_of(bank_ff, ss_ff)] : imm_ff;
   end

   // Execute and commit.
   always_comb begin
      logic take;
      take     = 1'b0;
      pc_in    = pc_ff + 1'b1;
      bank_in  = bank_ff;
      carry_in = carry_ff;
      halt_in  = halt_ff;
      fault_in = 1'b0;
      zh_in    = zh_ff;
      pinlv_in = pinlv_ff;
      wr_en    = 1'b0;
      wr_val   = b_ff;
      case (op_ff)
         OP_SET: wr_en = fr_ff;
         OP_ADD, OP_SUB, OP_MUL: if (fr_ff) begin
            wr_en    = 1'b1;
            wr_val   = alu_res;
            carry_in = alu_carry;
            zh_in    = {zh_ff[0], (alu_res == '0)};
         end
         OP_DIV, OP_MOD: if (fr_ff) begin
            wr_en    = (b_ff != '0);
            fault_in = (b_ff == '0);
            wr_val   = (op_ff == OP_DIV) ? quo : rem;
            zh_in    = {zh_ff[0], 1'b0};
            carry_in = (op_ff == OP_MOD);
         end
         OP_READ: begin
            wr_en  = fr_ff;
            wr_val = mem_rd;
         end
         OP_IF: begin
            case (cond_ff)
               CND_AEQB: take = (ra_ff == rb_ff);
               CND_AEQC: take = (ra_ff == rc_ff);
               CND_BEQC: take = (rb_ff == rc_ff);
               CND_AGTB: take = (ra_ff > rb_ff);
               CND_AGTC: take = (ra_ff > rc_ff);
               CND_CGTB: take = (rc_ff > rb_ff);
               CND_AND:  take = zh_ff[0] & zh_ff[1];
               CND_OR:   take = zh_ff[0] | zh_ff[1];
               CND_NOT:  take = !zh_ff[0];
               CND_XOR:  take = zh_ff[0] ^ zh_ff[1];
               default:  take = 1'b0;
            endcase
            if (take) pc_in = b_ff + 1'b1;
         end
         OP_JMP:  pc_in = a_ff + 1'b1;
         OP_BANK: if (b_ff < WORD_BITS'(BANK_COUNT)) bank_in = b_ff[BANK_BITS-1:0];
         OP_HALT: begin
            halt_in = 1'b1;
            pc_in   = pc_ff;
         end
         OP_OUT: if (a_ff < WORD_BITS'(PIN_COUNT)) begin
            pinlv_in[a_ff[3:0]] = (b_ff != '0);
         end
         OP_IN: begin
            wr_en  = fr_ff;
            wr_val = (b_ff < WORD_BITS'(PIN_COUNT)) ?
                     WORD_BITS'(pins_ff[b_ff[3:0]]) : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         bank_ff  <= '0;
         carry_ff <= 1'b0;
         halt_ff  <= 1'b0;
         fault_ff <= 1'b0;
         zh_ff    <= '0;
         pinlv_ff <= '0;
         for (int i = 0; i < SLOTS; i++) regs_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            pc_ff    <= pc_in;
            bank_ff  <= bank_in;
            carry_ff <= carry_in;
            halt_ff  <= halt_in;
            fault_ff <= fault_in;
            zh_ff    <= zh_in;
            pinlv_ff <= pinlv_in;
            if (wr_en) regs_ff[slot_f] <= wr_val;
         end else if (state_ff == ST_COMMIT) begin
            fault_ff <= 1'b0;
         end
      end
      if (req_ready && req_valid) begin
         op_ff   <= opcode_type'(req_opcode);
         fr_ff   <= req_first_is_reg;
         fs_ff   <= req_first_reg;
         sr_ff   <= req_second_is_reg;
         ss_ff   <= req_second_reg;
         imm_ff  <= req_immediate;
         cond_ff <= req_condition;
         pins_ff <= req_pins_in;
      end
      if (state_ff == ST_READ) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         ra_ff <= ra_in;
         rb_ff <= rb_in;
         rc_ff <= rc_in;
      end
   end

   assign rsp_next_pc      = pc_ff;
   assign rsp_halted       = halt_ff;
   assign rsp_pins_out     = pinlv_ff;
   assign rsp_carry_out    = carry_ff;
   assign rsp_zero_recent  = zh_ff[0];
   assign rsp_divide_fault = fault_ff;
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the banked 24-bit execute core.
// Needs bce_pkg and banked_24bit_cpu_execute_core; predicts every status word in line.
`default_nettype none
module tb_top;
   import bce_pkg::*;

   typedef struct {
      logic [3:0]  opcode;
      logic        first_is_reg;
      logic [1:0]  first_reg;
      logic        second_is_reg;
      logic [1:0]  second_reg;
      logic [23:0] immediate;
      logic [3:0]  condition;
      logic [15:0] pins_in;
   } instr_type;

   typedef struct {
      logic [23:0] next_pc;
      logic        halted;
      logic [15:0] pins_out;
      logic        carry_out;
      logic        zero_recent;
      logic        divide_fault;
   } status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0]  req_opcode = '0;
   logic        req_first_is_reg = 1'b0;
   logic [1:0]  req_first_reg = '0;
   logic        req_second_is_reg = 1'b0;
   logic [1:0]  req_second_reg = '0;
   logic [23:0] req_immediate = '0;
   logic [3:0]  req_condition = '0;
   logic [15:0] req_pins_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [23:0] rsp_next_pc;
   logic rsp_halted, rsp_carry_out, rsp_zero_recent, rsp_divide_fault;
   logic [15:0] rsp_pins_out;

   banked_24bit_cpu_execute_core i_dut (.*);

   // Predictor state.
   logic [23:0] regs [15];
   logic [23:0] dmem [logic [15:0]];
   logic [23:0] pc;
   logic [2:0]  bank;
   logic        carry;
   logic [1:0]  zhist;
   logic [15:0] pins;
   logic        halt;

   instr_type  pending_words[$];
   status_type expected_status[$];
   int      mismatches = 0;
   int      words_sent = 0;
   int      words_checked = 0;
   int      cycles = 0;
   bit      quiet = 1'b0;
   int      req_gap = 0;
   int      rsp_gap = 0;
   logic    req_done = 1'b0;

   initial forever #6 clock = ~clock;

   function automatic int slot(logic [1:0] sel);
      int s;
      s = (sel > 2) ? 2 : sel;
      return bank * 3 + s;
   endfunction

   function automatic bit cond_taken(logic [3:0] c);
      logic [23:0] a, b, k;
      a = regs[slot(2'd0)]; b = regs[slot(2'd1)]; k = regs[slot(2'd2)];
      case (c)
         CND_AEQB: return a == b;
         CND_AEQC: return a == k;
         CND_BEQC: return b == k;
         CND_AGTB: return a > b;
         CND_AGTC: return a > k;
         CND_CGTB: return k > b;
         CND_AND:  return zhist[0] & zhist[1];
         CND_OR:   return zhist[0] | zhist[1];
         CND_NOT:  return !zhist[0];
         CND_XOR:  return zhist[0] ^ zhist[1];
         default:  return 1'b0;
      endcase
   endfunction

   function automatic status_type execute_word(instr_type w);
      status_type s;
      logic [23:0] a, b, nxt, r;
      logic [47:0] t;
      s.divide_fault = 1'b0;
      if (!halt) begin
         a = w.first_is_reg ? regs[slot(w.first_reg)] : w.immediate;
         b = w.second_is_reg ? regs[slot(w.second_reg)] : w.immediate;
         nxt = pc + 24'd1;
         case (opcode_type'(w.opcode))
            OP_SET: if (w.first_is_reg) regs[slot(w.first_reg)] = b;
            OP_ADD, OP_SUB, OP_MUL: if (w.first_is_reg) begin
               if (w.opcode == OP_ADD) begin
                  t = a + b; carry = t > 48'hFFFFFF;
               end else if (w.opcode == OP_SUB) begin
                  t = a - b; carry = a < b;
               end else begin
                  t = a * b; carry = t > 48'hFFFFFF;
               end
               r = t[23:0];
               regs[slot(w.first_reg)] = r;
               zhist = {zhist[0], r == 0};
            end
            OP_DIV, OP_MOD: if (w.first_is_reg) begin
               if (b == 0) s.divide_fault = 1'b1;
               else regs[slot(w.first_reg)] = (w.opcode == OP_DIV) ? a / b : a % b;
               zhist = {zhist[0], 1'b0};
               carry = (w.opcode == OP_MOD);
            end
            OP_WRITE: dmem[a[15:0]] = b;
            OP_READ: if (w.first_is_reg)
               regs[slot(w.first_reg)] = dmem.exists(b[15:0]) ? dmem[b[15:0]] : 24'd0;
            OP_IF: if (cond_taken(w.condition)) nxt = b + 24'd1;
            OP_JMP: nxt = a + 24'd1;
            OP_BANK: if (b < BANK_COUNT_DEF) bank = b[2:0];
            OP_HALT: begin
               halt = 1'b1; nxt = pc;
            end
            OP_OUT: if (a < 16) pins[a[3:0]] = (b != 0);
            OP_IN: if (w.first_is_reg)
               regs[slot(w.first_reg)] = (b < 16) ? {23'd0, w.pins_in[b[3:0]]} : 24'd0;
            default: ;
         endcase
         pc = nxt;
      end
      s.next_pc = pc; s.halted = halt; s.pins_out = pins;
      s.carry_out = carry; s.zero_recent = zhist[0];
      return s;
   endfunction

   task automatic report_mismatch(string field, logic [23:0] got, logic [23:0] want);
      mismatches++;
      $display("mismatch on word %0d: %s got %0h expected %0h", words_checked, field, got, want);
   endtask

   // Random word; fix_read below keeps reads on written addresses so nothing undefined is fetched.
   function automatic instr_type random_word(bit allow_halt);
      instr_type w;
      w.opcode = 4'($urandom_range(0, 15));
      if (!allow_halt && w.opcode == OP_HALT) w.opcode = OP_ADD;
      w.first_is_reg = ($urandom_range(0, 9) != 0);
      w.first_reg = 2'($urandom_range(0, 3));
      w.second_is_reg = 1'($urandom_range(0, 1));
      w.second_reg = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0: w.immediate = 24'($urandom);
         1: w.immediate = 24'hFFFFFF - 24'($urandom_range(0, 3));
         2: w.immediate = 24'($urandom_range(0, 20));
         default: w.immediate = 24'($urandom_range(0, 4095));
      endcase
      w.condition = 4'($urandom_range(0, 15));
      w.pins_in = 16'($urandom);
      return w;
   endfunction

   // Memory reads are planned against a shadow of written addresses at build time.
   bit [15:0] written[$];

   function automatic void fix_read(ref instr_type w);
      if (w.opcode == OP_WRITE) begin
         // The value may come from a register; the address always comes from the immediate.
         if (w.first_is_reg) begin
            w.first_is_reg = 1'b0;
         end
         written.push_back(w.immediate[15:0]);
      end else if (w.opcode == OP_READ) begin
         if (written.size() == 0) w.opcode = OP_SET;
         else begin
            w.second_is_reg = 1'b0;
            w.immediate = {8'd0, written[$urandom_range(0, written.size() - 1)]};
         end
      end
   endfunction

   function automatic instr_type mk(logic [3:0] op, logic fr, logic [1:0] fs, logic sr,
                                    logic [1:0] ss, logic [23:0] imm, logic [3:0] c);
      instr_type w;
      w.opcode = op; w.first_is_reg = fr; w.first_reg = fs; w.second_is_reg = sr;
      w.second_reg = ss; w.immediate = imm; w.condition = c; w.pins_in = 16'hA5C3;
      return w;
   endfunction

   // Driver: falling edge, holds the word until it has been accepted.
   always @(negedge clock) begin
      instr_type w;
      if (!reset) begin
         if (!req_valid || req_done) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0 && (quiet || $urandom_range(0, 9) != 0))
            begin
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_opcode <= w.opcode; req_first_is_reg <= w.first_is_reg;
               req_first_reg <= w.first_reg; req_second_is_reg <= w.second_is_reg;
               req_second_reg <= w.second_reg; req_immediate <= w.immediate;
               req_condition <= w.condition; req_pins_in <= w.pins_in;
               expected_status.push_back(execute_word(w));
               words_sent++;
            end else begin
               if (pending_words.size() > 0) req_gap = $urandom_range(0, 13);
               req_valid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--; rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(0, 13); rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   // Monitor: samples the status word at the rising edge.
   always @(posedge clock) begin
      status_type e;
      cycles <= cycles + 1;
      req_done <= req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected status word", rsp_next_pc, 24'd0);
         end else begin
            e = expected_status.pop_front();
            if (rsp_next_pc !== e.next_pc) report_mismatch("next_pc", rsp_next_pc, e.next_pc);
            if (rsp_halted !== e.halted) report_mismatch("halted", rsp_halted, e.halted);
            if (rsp_pins_out !== e.pins_out) report_mismatch("pins_out", rsp_pins_out, e.pins_out);
            if (rsp_carry_out !== e.carry_out)
               report_mismatch("carry_out", rsp_carry_out, e.carry_out);
            if (rsp_zero_recent !== e.zero_recent)
               report_mismatch("zero_recent", rsp_zero_recent, e.zero_recent);
            if (rsp_divide_fault !== e.divide_fault)
               report_mismatch("divide_fault", rsp_divide_fault, e.divide_fault);
         end
         words_checked++;
      end
      if (cycles > 400000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      instr_type w;
      foreach (regs[i]) regs[i] = '0;
      pc = '0; bank = '0; carry = 1'b0; zhist = '0; pins = '0; halt = 1'b0;
      // Directed words: extremes, every opcode but halt and reserved 14, and the corner cases.
      pending_words.push_back(mk(OP_SET, 1'b1, 2'd0, 1'b0, 2'd0, 24'hFFFFFF, 4'd0));
      pending_words.push_back(mk(OP_ADD, 1'b1, 2'd0, 1'b0, 2'd0, 24'd1, 4'd0));
      pending_words.push_back(mk(OP_SUB, 1'b1, 2'd1, 1'b0, 2'd0, 24'd5, 4'd0));
      pending_words.push_back(mk(OP_SET, 1'b1, 2'd3, 1'b0, 2'd0, 24'd7, 4'd0));
      pending_words.push_back(mk(OP_MUL, 1'b1, 2'd1, 1'b1, 2'd1, 24'd0, 4'd0));
      pending_words.push_back(mk(OP_DIV, 1'b1, 2'd2, 1'b0, 2'd0, 24'd0, 4'd0));
      pending_words.push_back(mk(OP_MOD, 1'b1, 2'd1, 1'b1, 2'd2, 24'd0, 4'd0));
      pending_words.push_back(mk(OP_DIV, 1'b1, 2'd1, 1'b0, 2'd0, 24'd3, 4'd0));
      pending_words.push_back(mk(OP_ADD, 1'b0, 2'd0, 1'b0, 2'd0, 24'd9, 4'd0));
      pending_words.push_back(mk(OP_WRITE, 1'b0, 2'd0, 1'b1, 2'd1, 24'hFF1234, 4'd0));
      written.push_back(16'h1234);
      pending_words.push_back(mk(OP_READ, 1'b1, 2'd0, 1'b0, 2'd0, 24'h001234, 4'd0));
      pending_words.push_back(mk(OP_IF, 1'b0, 2'd0, 1'b0, 2'd0, 24'hFFFFFF, CND_NOT));
      pending_words.push_back(mk(OP_IF, 1'b0, 2'd0, 1'b0, 2'd0, 24'd40, 4'd12));
      pending_words.push_back(mk(OP_JMP, 1'b0, 2'd0, 1'b0, 2'd0, 24'hFFFFFF, 4'd0));
      pending_words.push_back(mk(OP_BANK, 1'b0, 2'd0, 1'b0, 2'd0, 24'd4, 4'd0));
      pending_words.push_back(mk(OP_BANK, 1'b0, 2'd0, 1'b0, 2'd0, 24'd5, 4'd0));
      pending_words.push_back(mk(OP_OUT, 1'b0, 2'd0, 1'b0, 2'd0, 24'd15, 4'd0));
      pending_words.push_back(mk(OP_OUT, 1'b0, 2'd0, 1'b0, 2'd0, 24'd16, 4'd0));
      pending_words.push_back(mk(OP_IN, 1'b1, 2'd2, 1'b0, 2'd0, 24'd0, 4'd0));
      pending_words.push_back(mk(OP_IN, 1'b1, 2'd2, 1'b0, 2'd0, 24'd20, 4'd0));
      pending_words.push_back(mk(OP_RSV15, 1'b0, 2'd0, 1'b0, 2'd0, 24'd0, 4'd0));
      pending_words.push_back(mk(OP_BANK, 1'b0, 2'd0, 1'b0, 2'd0, 24'd0, 4'd0));
      for (int i = 0; i < 1950; i++) begin
         w = random_word(1'b0);
         fix_read(w);
         pending_words.push_back(w);
      end
      // Halt near the end, then a few words that must be ignored.
      pending_words.push_back(mk(OP_HALT, 1'b0, 2'd0, 1'b0, 2'd0, 24'd0, 4'd0));
      for (int i = 0; i < 4; i++) pending_words.push_back(random_word(1'b1));
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() < 300);
      quiet = 1'b1;
      wait (pending_words.size() == 0 && expected_status.size() == 0);
      repeat (40) @(posedge clock);
      $display("checked %0d status words from %0d instruction words, all opcodes and halt",
               words_checked, words_sent);
      if (mismatches == 0 && expected_status.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire

// File: banked_24bit_cpu_execute_core.f
sv/bce_pkg.sv
sv/bce_ram.sv
sv/bce_divider.sv
sv/bce_alu.sv
sv/banked_24bit_cpu_execute_core.sv
dv/tb_top.sv
